// ===== rtl/core/tshp_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS ServerHello parser package
// Shared types and constants for the record header and ServerHello parser.
// ----------------------------------------------------------------------------
package tshp_pkg;

    // Status codes carried by a final record result.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD        = 2'd1;
    localparam logic [1:0] ST_ALERT      = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    // Result kinds.
    localparam logic KIND_RANDOM = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;

    // Record content types and ServerHello constants.
    localparam logic [7:0]  CT_ALERT       = 8'd21;
    localparam logic [7:0]  CT_HANDSHAKE   = 8'd22;
    localparam logic [7:0]  MSG_SERVER_HELLO = 8'd2;
    localparam logic [15:0] HELLO_MIN      = 16'd42;
    localparam logic [23:0] HS_LEN_MIN     = 24'd38;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  CFG_MAX_RECORD_LEN = 2'd0;
    localparam logic [1:0]  CFG_MIN_VERSION    = 2'd1;
    localparam logic [1:0]  CFG_MAX_VERSION    = 2'd2;
    localparam logic [15:0] RST_MAX_RECORD_LEN = 16'd2048;
    localparam logic [15:0] RST_MIN_VERSION    = 16'h0301;
    localparam logic [15:0] RST_MAX_VERSION    = 16'h0303;

    typedef struct packed {
        logic [15:0] max_record_len;
        logic [15:0] min_version;
        logic [15:0] max_version;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } rx_word_t;

    typedef struct packed {
        logic        out_kind;
        logic [4:0]  random_index;
        logic [7:0]  random_byte;
        logic [1:0]  status;
        logic [15:0] server_version;
        logic [15:0] chosen_suite;
    } result_t;

    // Handshake between the pipeline stages.
    typedef struct packed {
        logic valid;
        logic fire;
    } stage_ctl_t;

endpackage

// ===== rtl/core/tshp_if.sv =====
// ----------------------------------------------------------------------------
// TLS ServerHello parser channel interfaces
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface tshp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tshp_res_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [4:0]  random_index;
    logic [7:0]  random_byte;
    logic [1:0]  status;
    logic [15:0] server_version;
    logic [15:0] chosen_suite;

    modport source (output valid, output out_kind, output random_index,
                    output random_byte, output status, output server_version,
                    output chosen_suite, input ready);
    modport sink   (input valid, input out_kind, input random_index,
                    input random_byte, input status, input server_version,
                    input chosen_suite, output ready);
endinterface

// ===== rtl/core/tshp_in_stage.sv =====
// ----------------------------------------------------------------------------
// TLS ServerHello parser input stage
// Registers one received word and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module tshp_in_stage
    import tshp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rx_word_t   in_word,
    input  logic       take,
    output logic       word_valid,
    output rx_word_t   word
);

    logic     valid_reg;
    rx_word_t word_reg;

    // A new word may enter when the stage is empty or is being emptied.
    assign in_ready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

// ===== rtl/core/tshp_parser.sv =====
// ----------------------------------------------------------------------------
// TLS ServerHello parser core logic
// Record header and ServerHello state machine, one byte per accepted word.
// ----------------------------------------------------------------------------
module tshp_parser
    import tshp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  stage_ctl_t ctl,
    input  rx_word_t   word,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [15:0] pos_reg,     pos_next;
    logic [15:0] rlen_reg,    rlen_next;
    logic [7:0]  ctype_reg,   ctype_next;
    logic [23:0] hlen_reg,    hlen_next;
    logic [15:0] hver_reg,    hver_next;
    logic [7:0]  sid_reg,     sid_next;
    logic [15:0] suite_reg,   suite_next;
    logic [1:0]  lst_reg,     lst_next;
    logic        latched_reg, latched_next;
    logic        hbad_reg,    hbad_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [16:0] pos_w;
        logic [16:0] pos_inc;
        logic [16:0] sl_w;
        logic [24:0] hlen_sum;
        logic [16:0] sid_end;
        logic        rand_out;

        b        = word.data_byte;
        rand_out = 1'b0;
        pos_w    = 17'd0;
        pos_inc  = 17'd0;
        sl_w     = 17'd0;
        hlen_sum = 25'd0;
        sid_end  = 17'd0;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        rlen_next    = rlen_reg;
        ctype_next   = ctype_reg;
        hlen_next    = hlen_reg;
        hver_next    = hver_reg;
        sid_next     = sid_reg;
        suite_next   = suite_reg;
        lst_next     = lst_reg;
        latched_next = latched_reg;
        hbad_next    = hbad_reg;

        res_valid = 1'b0;
        res       = '0;

        if (ctl.fire)
        begin
            // A frame start abandons whatever record was in progress.
            if (word.frame_start)
            begin
                phase_next   = PH_HEADER;
                pos_next     = 16'd0;
                rlen_next    = 16'd0;
                ctype_next   = 8'd0;
                hlen_next    = 24'd0;
                hver_next    = 16'd0;
                sid_next     = 8'd0;
                suite_next   = 16'd0;
                lst_next     = ST_OK;
                latched_next = 1'b0;
                hbad_next    = 1'b0;
            end

            case (phase_next)
                PH_HEADER:
                begin
                    if (pos_next == 16'd0)
                    begin
                        ctype_next = b;
                    end
                    else
                    begin
                        rlen_next = {rlen_next[7:0], b};
                        // The first two bytes after the type are the version.
                        if (pos_next == 16'd2)
                        begin
                            if (rlen_next < cfg.min_version || rlen_next > cfg.max_version)
                            begin
                                hbad_next = 1'b1;
                            end
                            rlen_next = 16'd0;
                        end
                    end

                    if (pos_next < 16'd4)
                    begin
                        pos_next = pos_next + 16'd1;
                    end
                    else if (hbad_next || rlen_next > cfg.max_record_len)
                    begin
                        res_valid      = 1'b1;
                        res.out_kind   = KIND_FINAL;
                        res.status     = ST_BAD;
                        res.server_version = hver_next;
                        res.chosen_suite   = suite_next;
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        if (ctype_next == CT_ALERT)
                        begin
                            lst_next     = ST_ALERT;
                            latched_next = 1'b1;
                        end
                        else if (ctype_next != CT_HANDSHAKE || rlen_next < HELLO_MIN)
                        begin
                            lst_next     = ST_UNEXPECTED;
                            latched_next = 1'b1;
                        end
                        pos_next = 16'd0;
                        if (rlen_next == 16'd0)
                        begin
                            res_valid      = 1'b1;
                            res.out_kind   = KIND_FINAL;
                            res.status     = lst_next;
                            res.server_version = hver_next;
                            res.chosen_suite   = suite_next;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end

                PH_BODY:
                begin
                    pos_w = {1'b0, pos_next};
                    sl_w  = {9'd0, sid_next};
                    if (!latched_next)
                    begin
                        if (pos_next == 16'd0)
                        begin
                            if (b != MSG_SERVER_HELLO)
                            begin
                                lst_next     = ST_UNEXPECTED;
                                latched_next = 1'b1;
                            end
                        end
                        else if (pos_next <= 16'd3)
                        begin
                            hlen_next = {hlen_next[15:0], b};
                            hlen_sum  = {1'b0, hlen_next} + 25'd4;
                            if (pos_next == 16'd3 &&
                                (hlen_sum > {9'd0, rlen_next} || hlen_next < HS_LEN_MIN))
                            begin
                                lst_next     = ST_BAD;
                                latched_next = 1'b1;
                            end
                        end
                        else if (pos_next <= 16'd5)
                        begin
                            hver_next = {hver_next[7:0], b};
                        end
                        else if (pos_next <= 16'd37)
                        begin
                            rand_out         = 1'b1;
                            res_valid        = 1'b1;
                            res.out_kind     = KIND_RANDOM;
                            res.random_index = 5'(pos_next - 16'd6);
                            res.random_byte  = b;
                        end
                        else if (pos_next == 16'd38)
                        begin
                            sid_next = b;
                            // Room is needed for the suite and the compression byte.
                            sid_end  = 17'd42 + {9'd0, b};
                            if (sid_end > {1'b0, rlen_next})
                            begin
                                lst_next     = ST_BAD;
                                latched_next = 1'b1;
                            end
                        end
                        else if (pos_w == sl_w + 17'd39 || pos_w == sl_w + 17'd40)
                        begin
                            suite_next = {suite_next[7:0], b};
                        end
                        else if (pos_w == sl_w + 17'd41)
                        begin
                            if (b != 8'd0)
                            begin
                                lst_next     = ST_UNEXPECTED;
                                latched_next = 1'b1;
                            end
                        end
                    end

                    pos_inc  = pos_w + 17'd1;
                    pos_next = pos_inc[15:0];
                    if (pos_inc >= {1'b0, rlen_next} && !rand_out)
                    begin
                        res_valid          = 1'b1;
                        res.out_kind       = KIND_FINAL;
                        res.status         = latched_next ? lst_next : ST_OK;
                        res.server_version = hver_next;
                        res.chosen_suite   = suite_next;
                        phase_next         = PH_DONE;
                    end
                end

                default:
                begin
                    // Idle or finished: stray bytes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= 16'd0;
            rlen_reg    <= 16'd0;
            ctype_reg   <= 8'd0;
            hlen_reg    <= 24'd0;
            hver_reg    <= 16'd0;
            sid_reg     <= 8'd0;
            suite_reg   <= 16'd0;
            lst_reg     <= ST_OK;
            latched_reg <= 1'b0;
            hbad_reg    <= 1'b0;
        end
        else if (ctl.valid)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rlen_reg    <= rlen_next;
            ctype_reg   <= ctype_next;
            hlen_reg    <= hlen_next;
            hver_reg    <= hver_next;
            sid_reg     <= sid_next;
            suite_reg   <= suite_next;
            lst_reg     <= lst_next;
            latched_reg <= latched_next;
            hbad_reg    <= hbad_next;
        end
    end

endmodule

// ===== rtl/core/tshp_out_stage.sv =====
// ----------------------------------------------------------------------------
// TLS ServerHello parser output stage
// Result register that holds a word until the receiver takes it.
// ----------------------------------------------------------------------------
module tshp_out_stage
    import tshp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    output logic    space,
    tshp_res_if.source res_out
);

    logic    valid_reg;
    result_t res_reg;

    assign space = !valid_reg || res_out.ready;

    assign res_out.valid          = valid_reg;
    assign res_out.out_kind       = res_reg.out_kind;
    assign res_out.random_index   = res_reg.random_index;
    assign res_out.random_byte    = res_reg.random_byte;
    assign res_out.status         = res_reg.status;
    assign res_out.server_version = res_reg.server_version;
    assign res_out.chosen_suite   = res_reg.chosen_suite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== rtl/core/tls_server_hello_record_parser_core.sv =====
// ----------------------------------------------------------------------------
// TLS record header and ServerHello parser
// Parses a received byte stream, gives out the server random and a status.
// ----------------------------------------------------------------------------
// The rx channel carries one received byte per word together with a frame
// start flag that marks the first header byte of a record. The hello channel
// carries result words: one word per server random byte, and one final word
// with the record status, the ServerHello version and the selected suite at
// the end of each record (or right after the header for a bad header or an
// empty body). Bytes outside a record produce no result.
// Each accepted byte is held in the input register and parsed once the output
// register has space; its result, if any, is loaded into the output register
// at the edge that takes the byte and is offered until the receiver takes it.
// One byte is accepted every cycle while the receiver keeps taking results;
// each result is worked out combinationally between the input and output
// registers. When the receiver stalls with a result waiting, the parser
// holds, the input register fills, and rx.ready drops until the result is
// taken. Reset empties both registers, returns the parser to waiting for a
// frame start and loads the configuration registers with their default values.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tls_server_hello_record_parser_core
    import tshp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    tshp_rx_if.sink     rx,
    tshp_res_if.source  hello
);

    cfg_t       cfg_reg;
    rx_word_t   rx_word;
    rx_word_t   word;
    logic       word_valid;
    logic       space;
    logic       take;
    logic       res_valid;
    result_t    res;
    stage_ctl_t ctl;

    // Configuration registers. Writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_record_len <= RST_MAX_RECORD_LEN;
            cfg_reg.min_version    <= RST_MIN_VERSION;
            cfg_reg.max_version    <= RST_MAX_VERSION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_RECORD_LEN: cfg_reg.max_record_len <= cfg_wdata;
                CFG_MIN_VERSION:    cfg_reg.min_version    <= cfg_wdata;
                CFG_MAX_VERSION:    cfg_reg.max_version    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign rx_word.data_byte   = rx.data_byte;
    assign rx_word.frame_start = rx.frame_start;

    // The parser advances whenever a byte is waiting and the result register
    // can take whatever that byte produces.
    assign take      = word_valid && space;
    assign ctl.valid = take;
    assign ctl.fire  = take;

    tshp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_ready   (rx.ready),
        .in_word    (rx_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    tshp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    tshp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && res_valid),
        .load_res (res),
        .space    (space),
        .res_out  (hello)
    );

endmodule
